>>> rtl/sida_pkg.sv
// ----------------------------------------------------------------------------
// sida_pkg: shared types and constants for the integer to decimal text block
// Widths, character codes and the word passed from the converter to the
// character emitter.
// ----------------------------------------------------------------------------
package sida_pkg;

    localparam int BIN_W      = 32;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int CHAR_W     = 7;
    localparam int CNT_W      = $clog2(BIN_W);
    localparam int NDIG_W     = $clog2(NUM_DIGITS + 1);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;

    // converted number handed to the emitter
    typedef struct packed {
        logic             neg;
        logic [BCD_W-1:0] bcd;
    } bcd_word_t;

    // double dabble correction of one digit before the shift
    function automatic logic [3:0] add3(input logic [3:0] d);
        logic [3:0] r;
        r = (d >= 4'd5) ? d + 4'd3 : d;
        return r;
    endfunction

endpackage

>>> rtl/sida_dabble.sv
// ----------------------------------------------------------------------------
// sida_dabble: bit-serial binary to BCD converter
// Takes the magnitude of a signed word and shifts it into a BCD register one
// bit per cycle, correcting each digit on the way (double dabble).
// ----------------------------------------------------------------------------
module sida_dabble (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [sida_pkg::BIN_W-1:0]    in_value,
    output logic                          res_valid,
    input  logic                          res_ack,
    output sida_pkg::bcd_word_t           res_word
);
    import sida_pkg::*;

    typedef enum logic [2:0] {
        D_IDLE  = 3'b001,
        D_SHIFT = 3'b010,
        D_DONE  = 3'b100
    } dab_state_t;

    dab_state_t         state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [BIN_W-1:0]   bin_reg, bin_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic               neg_reg, neg_next;
    logic [BCD_W-1:0]   bcd_adj;

    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            bcd_adj[4*i +: 4] = add3(bcd_reg[4*i +: 4]);
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        neg_next   = neg_reg;
        unique case (state_reg)
            D_IDLE: begin
                if (in_valid) begin
                    neg_next   = in_value[BIN_W-1];
                    // most negative value negates to itself, the right magnitude
                    bin_next   = in_value[BIN_W-1] ? (~in_value + BIN_W'(1)) : in_value;
                    bcd_next   = '0;
                    cnt_next   = '0;
                    state_next = D_SHIFT;
                end
            end
            D_SHIFT: begin
                bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[BIN_W-1]};
                bin_next = {bin_reg[BIN_W-2:0], 1'b0};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(BIN_W - 1)) begin
                    state_next = D_DONE;
                end
            end
            D_DONE: begin
                if (res_ack) begin
                    state_next = D_IDLE;
                end
            end
            default: state_next = D_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
        end else begin
            state_reg <= state_next;
        end
        cnt_reg <= cnt_next;
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
        neg_reg <= neg_next;
    end

    assign in_ready     = (state_reg == D_IDLE);
    assign res_valid    = (state_reg == D_DONE);
    assign res_word.neg = neg_reg;
    assign res_word.bcd = bcd_reg;

endmodule

>>> rtl/sida_emit.sv
// ----------------------------------------------------------------------------
// sida_emit: character emitter
// Drops leading zero digits one per cycle, then sends the minus sign for a
// negative value and the digits most significant first through a registered output stage.
// ----------------------------------------------------------------------------
module sida_emit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          res_valid,
    output logic                          res_ack,
    input  sida_pkg::bcd_word_t           res_word,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [sida_pkg::CHAR_W-1:0]   out_char,
    output logic                          out_last
);
    import sida_pkg::*;

    typedef enum logic [3:0] {
        E_IDLE  = 4'b0001,
        E_TRIM  = 4'b0010,
        E_SIGN  = 4'b0100,
        E_DIGIT = 4'b1000
    } emit_state_t;

    emit_state_t        state_reg, state_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic               neg_reg, neg_next;
    logic [NDIG_W-1:0]  ndig_reg, ndig_next;
    logic               vld_reg, vld_next;
    logic [CHAR_W-1:0]  char_reg, char_next;
    logic               last_reg, last_next;
    logic               out_free;
    logic [3:0]         top_digit;

    assign out_free  = !vld_reg || out_ready;
    assign top_digit = bcd_reg[BCD_W-1 -: 4];

    always_comb begin
        state_next = state_reg;
        bcd_next   = bcd_reg;
        neg_next   = neg_reg;
        ndig_next  = ndig_reg;
        vld_next   = vld_reg && !out_ready;
        char_next  = char_reg;
        last_next  = last_reg;
        res_ack    = 1'b0;
        unique case (state_reg)
            E_IDLE: begin
                if (res_valid) begin
                    res_ack    = 1'b1;
                    bcd_next   = res_word.bcd;
                    neg_next   = res_word.neg;
                    ndig_next  = NDIG_W'(NUM_DIGITS);
                    state_next = E_TRIM;
                end
            end
            E_TRIM: begin
                // keep at least one digit so zero prints as a single '0'
                if (top_digit == 4'd0 && ndig_reg != NDIG_W'(1)) begin
                    bcd_next  = {bcd_reg[BCD_W-5:0], 4'd0};
                    ndig_next = ndig_reg - NDIG_W'(1);
                end else begin
                    state_next = neg_reg ? E_SIGN : E_DIGIT;
                end
            end
            E_SIGN: begin
                if (out_free) begin
                    vld_next   = 1'b1;
                    char_next  = CHAR_MINUS;
                    last_next  = 1'b0;
                    state_next = E_DIGIT;
                end
            end
            E_DIGIT: begin
                if (out_free) begin
                    vld_next  = 1'b1;
                    char_next = CHAR_ZERO + CHAR_W'(top_digit);
                    last_next = (ndig_reg == NDIG_W'(1));
                    bcd_next  = {bcd_reg[BCD_W-5:0], 4'd0};
                    ndig_next = ndig_reg - NDIG_W'(1);
                    if (ndig_reg == NDIG_W'(1)) begin
                        state_next = E_IDLE;
                    end
                end
            end
            default: state_next = E_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= E_IDLE;
            vld_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            vld_reg   <= vld_next;
        end
        bcd_reg  <= bcd_next;
        neg_reg  <= neg_next;
        ndig_reg <= ndig_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign out_valid = vld_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;

endmodule

>>> rtl/signed_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii: signed 32-bit integer to decimal ASCII text
//
//   channel | direction | payload
//   s_      | in        | tdata[31:0] value, signed
//   m_      | out       | tdata[6:0] char_code, tdata[7] zero; tlast on final char
//
// A word is converted by taking its magnitude and then running bit-serial
// double dabble shifts, one per input bit. The emitter then loads the word,
// drops leading zeros (up to 9 shifts before it moves on), and sends each
// character (1 to 11) through its output register.
// Conversion of the next word overlaps emission of the current one.
// Reset is synchronous, active low, and needs no clearing pass.
// A stalled m_tready holds the output register and backs up into the converter.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [6:0] char_code, [7] zero
    output logic        m_tlast
);
    import sida_pkg::*;

    logic              res_valid;
    logic              res_ack;
    bcd_word_t         res_word;
    logic [CHAR_W-1:0] out_char;

    sida_dabble u_dabble (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_value  (s_tdata),
        .res_valid (res_valid),
        .res_ack   (res_ack),
        .res_word  (res_word)
    );

    sida_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res_ack   (res_ack),
        .res_word  (res_word),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (out_char),
        .out_last  (m_tlast)
    );

    assign m_tdata = {1'b0, out_char};

endmodule
